/* sv/phr_pkg.sv */
// phr_pkg: shared types, constants and helpers for the pixel hue rotate unit
// fixed point: hue in 1/64 degree, saturation and value with 16 fraction bits
// no dependencies
package phr_pkg;

   localparam int SV_FRAC = 16;

   localparam logic [14:0] HUE_FULL       = 15'd23040;
   localparam logic [11:0] HUE_SIXTH      = 12'd3840;
   localparam logic [14:0] HUE_BASE_GREEN = 15'd7680;
   localparam logic [14:0] HUE_BASE_BLUE  = 15'd15360;
   localparam logic [16:0] SV_ONE         = 17'h10000;

   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   typedef enum logic [7:0] {
      CSR_MODE       = 8'd0,
      CSR_HUE_CENTER = 8'd1,
      CSR_HUE_RADIUS = 8'd2,
      CSR_HUE_SHIFT  = 8'd3
   } csr_index_type;

   typedef enum logic {
      MODE_ROTATE,
      MODE_SATURATE
   } mode_type;

   typedef struct packed {
      logic       last;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      mode_type           mode;
      logic [14:0]        hue_center;
      logic [13:0]        hue_radius;
      logic signed [15:0] hue_shift;
   } phr_cfg_type;

   // classified pixel as kept in the queue
   typedef struct packed {
      pixel_type   pix;
      logic [7:0]  mx;
      logic [7:0]  d;
      logic [7:0]  adiff;
      logic        neg;
      max_sel_type sel;
      logic [16:0] v;
   } phr_item_type;

   typedef struct packed {
      logic         valid;
      phr_item_type item;
   } phr_front_out_type;

   // sideband carried alongside the fraction stage
   typedef struct packed {
      pixel_type   pix;
      logic        hit;
      logic [2:0]  sector;
      logic [16:0] s;
      logic [16:0] v;
   } phr_mid_type;

   // trunc(x * 255 / 2^16) clamped to a byte
   function automatic logic [7:0] to_byte(input logic [16:0] x);
      logic [24:0] prod;
      logic [8:0]  c;
      prod = ({8'd0, x} << 8) - {8'd0, x};
      c    = prod[24:16];
      return (c > 9'd255) ? 8'd255 : c[7:0];
   endfunction

endpackage

/* sv/phr_div.sv */
// phr_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; quotient must fit in QW bits
module phr_div #(
   parameter int NW = 20,
   parameter int DW = 8,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   localparam int W = NW + DW + QW;

   logic [W-1:0]  rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] q_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [W-1:0]  rem_src;
      logic [W-1:0]  sub;
      logic [DW-1:0] den_src;
      logic [QW-1:0] q_src;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_src = W'(num);
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      assign sub = W'(den_src) << (QW - 1 - k);
      assign ge  = rem_src >= sub;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? (rem_src - sub) : rem_src;
            den_ff[k] <= den_src;
            q_ff[k]   <= q_src | (QW'(ge) << (QW - 1 - k));
         end
      end
   end

   assign quo = q_ff[QW-1];

endmodule

/* sv/phr_front.sv */
// phr_front: accepts pixels, finds max, min and hue sector inputs, queues them
// depends on phr_pkg
module phr_front
   import phr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  pixel_type                  in_pix,
   output phr_front_out_type          out,
   input  logic                       pop,
   output logic [$clog2(DEPTH+1)-1:0] fill
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH);

   phr_item_type     cls;
   phr_item_type     q_mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             push;
   logic signed [8:0] diff;
   logic [7:0]       r, g, b, mx, mn;

   assign r = in_pix.red;
   assign g = in_pix.green;
   assign b = in_pix.blue;

   always_comb begin
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      cls.pix = in_pix;
      cls.mx  = mx;
      cls.d   = mx - mn;
      if (mx == r) begin
         cls.sel = MAX_RED;
         diff    = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (mx == g) begin
         cls.sel = MAX_GREEN;
         diff    = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         cls.sel = MAX_BLUE;
         diff    = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      cls.neg   = diff[8];
      cls.adiff = diff[8] ? 8'(-diff) : diff[7:0];
      // ceil(mx * 2^16 / 255) = mx * 257 + (mx != 0)
      cls.v     = {1'b0, mx, mx} + 17'(mx != 8'd0);
   end

   assign in_ready = fill_ff != CW'(DEPTH);
   assign push     = in_valid && in_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cls;
      end
   end

   assign out.valid = fill_ff != '0;
   assign out.item  = q_mem[rd_ptr_ff];
   assign fill      = fill_ff;

endmodule

/* sv/phr_back.sv */
// phr_back: hue and saturation dividers, window test, shift, and conversion back to rgb
// depends on phr_pkg and phr_div
module phr_back
   import phr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  phr_cfg_type       cfg,
   input  phr_front_out_type in,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output pixel_type         out_pix,
   output logic              out_changed
);

   localparam int DIV1_LAT = 17;

   logic en;

   // ---- first dividers: hue and saturation
   logic [16:0]  h_quo, s_quo;
   phr_item_type dl_item_ff [DIV1_LAT];
   logic         dl_vld_ff  [DIV1_LAT];

   assign en  = !out_valid || out_ready;
   assign pop = en && in.valid;

   phr_div #(.NW(20), .DW(8), .QW(DIV1_LAT)) u_hdiv (
      .clock (clock),
      .en    (en),
      .num   (20'(in.item.adiff) * 20'(HUE_SIXTH)),
      .den   (in.item.d),
      .quo   (h_quo)
   );

   phr_div #(.NW(24), .DW(8), .QW(DIV1_LAT)) u_sdiv (
      .clock (clock),
      .en    (en),
      .num   ({in.item.d, 16'd0}),
      .den   (in.item.mx),
      .quo   (s_quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dl_item_ff[0] <= in.item;
         for (int k = 1; k < DIV1_LAT; k++) begin
            dl_item_ff[k] <= dl_item_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV1_LAT; k++) begin
            dl_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         dl_vld_ff[0] <= in.valid;
         for (int k = 1; k < DIV1_LAT; k++) begin
            dl_vld_ff[k] <= dl_vld_ff[k-1];
         end
      end
   end

   // ---- h1: signed hue, wrapped positive
   phr_item_type       it;
   logic [14:0]        base;
   logic signed [16:0] hq_s, hp;
   logic [14:0]        h1_in, h1_ff;
   logic [16:0]        s1_in, s1_ff, v1_ff;
   pixel_type          pix1_ff;
   logic               gray1_ff, mxz1_ff, vld1_ff;

   assign it = dl_item_ff[DIV1_LAT-1];

   always_comb begin
      case (it.sel)
         MAX_GREEN: base = HUE_BASE_GREEN;
         MAX_BLUE:  base = HUE_BASE_BLUE;
         default:   base = '0;
      endcase
      hq_s = $signed({5'd0, h_quo[11:0]});
      hp   = $signed({2'b00, base}) + (it.neg ? -hq_s : hq_s);
      if (it.d == 8'd0) begin
         h1_in = '0;
      end else if (hp < 0) begin
         h1_in = 15'(hp + $signed({2'b00, HUE_FULL}));
      end else begin
         h1_in = hp[14:0];
      end
      s1_in = (it.mx == 8'd0) ? '0 : s_quo;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_ff    <= h1_in;
         s1_ff    <= s1_in;
         v1_ff    <= it.v;
         pix1_ff  <= it.pix;
         gray1_ff <= it.d == 8'd0;
         mxz1_ff  <= it.mx == 8'd0;
      end
   end

   // ---- h2: window test and shift, or saturate
   logic signed [17:0] lo, hi, hs, hlow, hhigh, x;
   logic [14:0]        hw, h2_in, h2_ff;
   logic               win, hit2_in, hit2_ff, vld2_ff;
   logic [16:0]        s2_in, s2_ff, v2_in, v2_ff;
   pixel_type          pix2_ff;

   always_comb begin
      lo    = $signed({3'b000, cfg.hue_center}) - $signed({4'b0000, cfg.hue_radius});
      hi    = $signed({3'b000, cfg.hue_center}) + $signed({4'b0000, cfg.hue_radius});
      hs    = $signed({3'b000, h1_ff});
      hlow  = hs - $signed({3'b000, HUE_FULL});
      hhigh = hs + $signed({3'b000, HUE_FULL});
      win   = (hs >= lo && hs <= hi)
            || (lo < 0 && hlow >= lo && hlow <= hi)
            || (hi > $signed({3'b000, HUE_FULL}) && hhigh >= lo && hhigh <= hi);
      // shifted hue modulo a full turn, sum lies above minus two turns and below three turns
      x = hs + 18'(cfg.hue_shift);
      if (x < -$signed({3'b000, HUE_FULL})) begin
         hw = 15'(x + $signed({2'b00, HUE_FULL, 1'b0}));
      end else if (x < 0) begin
         hw = 15'(x + $signed({3'b000, HUE_FULL}));
      end else if (x < $signed({3'b000, HUE_FULL})) begin
         hw = x[14:0];
      end else if (x < $signed({2'b00, HUE_FULL, 1'b0})) begin
         hw = 15'(x - $signed({3'b000, HUE_FULL}));
      end else begin
         hw = 15'(x - $signed({2'b00, HUE_FULL, 1'b0}));
      end
      h2_in = h1_ff;
      s2_in = s1_ff;
      v2_in = v1_ff;
      if (cfg.mode == MODE_SATURATE) begin
         hit2_in = !mxz1_ff && !gray1_ff;
         if (hit2_in) begin
            s2_in = SV_ONE;
            v2_in = SV_ONE;
         end
      end else begin
         hit2_in = win;
         if (win) begin
            h2_in = hw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h2_ff   <= h2_in;
         s2_ff   <= s2_in;
         v2_ff   <= v2_in;
         hit2_ff <= hit2_in;
         pix2_ff <= pix1_ff;
      end
   end

   // ---- h3: sector and remainder within the sector
   logic [2:0]  sec_in, sec3_ff;
   logic [11:0] rem_in, rem3_ff;
   logic [16:0] s3_ff, v3_ff;
   logic        hit3_ff, vld3_ff;
   pixel_type   pix3_ff;

   always_comb begin
      if (h2_ff < 15'(HUE_SIXTH)) begin
         sec_in = 3'd0;
         rem_in = h2_ff[11:0];
      end else if (h2_ff < 15'(2 * HUE_SIXTH)) begin
         sec_in = 3'd1;
         rem_in = 12'(h2_ff - 15'(HUE_SIXTH));
      end else if (h2_ff < 15'(3 * HUE_SIXTH)) begin
         sec_in = 3'd2;
         rem_in = 12'(h2_ff - 15'(2 * HUE_SIXTH));
      end else if (h2_ff < 15'(4 * HUE_SIXTH)) begin
         sec_in = 3'd3;
         rem_in = 12'(h2_ff - 15'(3 * HUE_SIXTH));
      end else if (h2_ff < 15'(5 * HUE_SIXTH)) begin
         sec_in = 3'd4;
         rem_in = 12'(h2_ff - 15'(4 * HUE_SIXTH));
      end else begin
         sec_in = 3'd5;
         rem_in = 12'(h2_ff - 15'(5 * HUE_SIXTH));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sec3_ff <= sec_in;
         rem3_ff <= rem_in;
         s3_ff   <= s2_ff;
         v3_ff   <= v2_ff;
         hit3_ff <= hit2_ff;
         pix3_ff <= pix2_ff;
      end
   end

   // ---- fraction: f = rem * 2^16 / 3840 = rem * 256 / 15, by reciprocal
   // 1118482 = ceil(2^24 / 15), exact for every remainder within one sector
   localparam logic [20:0] FRAC_RECIP = 21'd1118482;

   logic [31:0] f_prod;
   logic [15:0] f_ff;
   phr_mid_type mid_in, mf_ff;
   logic        mf_vld_ff;

   assign f_prod = 32'(rem3_ff) * 32'(FRAC_RECIP);
   assign mid_in = '{pix: pix3_ff, hit: hit3_ff, sector: sec3_ff, s: s3_ff, v: v3_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff  <= f_prod[31:16];
         mf_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff   <= 1'b0;
         vld2_ff   <= 1'b0;
         vld3_ff   <= 1'b0;
         mf_vld_ff <= 1'b0;
      end else if (en) begin
         vld1_ff   <= dl_vld_ff[DIV1_LAT-1];
         vld2_ff   <= vld1_ff;
         vld3_ff   <= vld2_ff;
         mf_vld_ff <= vld3_ff;
      end
   end

   // ---- m1: f * s, (1 - f) * s, p
   phr_mid_type m;
   logic [33:0] fs_prod, gs_prod, p_prod;
   logic [16:0] fs1_ff, gs1_ff, p1_ff;
   phr_mid_type m1_ff;
   logic        m1_vld_ff;

   assign m       = mf_ff;
   assign fs_prod = {1'b0, f_ff} * m.s;
   assign gs_prod = (SV_ONE - {1'b0, f_ff}) * m.s;
   assign p_prod  = m.v * (SV_ONE - m.s);

   always_ff @(posedge clock) begin
      if (en) begin
         fs1_ff <= fs_prod[32:16];
         gs1_ff <= gs_prod[32:16];
         p1_ff  <= p_prod[32:16];
         m1_ff  <= m;
      end
   end

   // ---- m2: q and t
   logic [33:0] q_prod, t_prod;
   logic [16:0] q2_ff, t2_ff, p2_ff;
   phr_mid_type m2_ff;
   logic        m2_vld_ff;

   assign q_prod = m1_ff.v * (SV_ONE - fs1_ff);
   assign t_prod = m1_ff.v * (SV_ONE - gs1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         q2_ff <= q_prod[32:16];
         t2_ff <= t_prod[32:16];
         p2_ff <= p1_ff;
         m2_ff <= m1_ff;
      end
   end

   // ---- output register: sector select, scale to bytes, pass through
   logic [16:0] cr, cg, cb;
   pixel_type   opix_in, opix_ff;
   logic        ochg_ff, ovld_ff;

   always_comb begin
      case (m2_ff.sector)
         3'd0: begin cr = m2_ff.v; cg = t2_ff;   cb = p2_ff;   end
         3'd1: begin cr = q2_ff;   cg = m2_ff.v; cb = p2_ff;   end
         3'd2: begin cr = p2_ff;   cg = m2_ff.v; cb = t2_ff;   end
         3'd3: begin cr = p2_ff;   cg = q2_ff;   cb = m2_ff.v; end
         3'd4: begin cr = t2_ff;   cg = p2_ff;   cb = m2_ff.v; end
         default: begin cr = m2_ff.v; cg = p2_ff; cb = q2_ff; end
      endcase
      opix_in = m2_ff.pix;
      if (m2_ff.hit) begin
         opix_in.red   = to_byte(cr);
         opix_in.green = to_byte(cg);
         opix_in.blue  = to_byte(cb);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         opix_ff <= opix_in;
         ochg_ff <= m2_ff.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         ovld_ff   <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= mf_vld_ff;
         m2_vld_ff <= m1_vld_ff;
         ovld_ff   <= m2_vld_ff;
      end
   end

   assign out_valid   = ovld_ff;
   assign out_pix     = opix_ff;
   assign out_changed = ochg_ff;

endmodule

/* sv/pixel_hue_rotate_unit.sv */
// pixel_hue_rotate_unit: top level of the per-pixel hue rotate / saturate block
// depends on phr_pkg, phr_front, phr_back (and phr_div below it)
//
// One bgr pixel word per cycle goes in and one word per cycle comes out, in
// order. A result word takes longer to appear when it is accepted while other
// words still wait in the queue ahead of it. The front stage finds
// max, min and hue operands and writes a small queue; the back end is a
// stall-as-a-whole pipeline: two 17-stage restoring dividers (hue and
// saturation), three stages for hue wrap, window test with shift and sector
// split, one reciprocal multiply stage for the sector fraction, two multiply
// stages and the output register. Throughput is one pixel per cycle whenever
// the result side takes words; the queue absorbs input while the output is
// held. The csr port is always ready; registers should be written only while
// no pixel is in flight, and an index above 3 is ignored. Unchanged pixels
// come out with their input bytes and tuser low.
module pixel_hue_rotate_unit
   import phr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   input  logic        req_tlast,
   // pixel result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // blue[7:0], green[15:8], red[23:16]
   output logic        rsp_tuser,   // changed
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   phr_cfg_type       cfg_ff, cfg_in;
   pixel_type         in_pix, out_pix;
   phr_front_out_type front_out;
   logic              pop;
   logic [CW-1:0]     fill;

   // register file, written any time the port is valid
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:       cfg_in.mode       = mode_type'(csr_data[0]);
            CSR_HUE_CENTER: cfg_in.hue_center = csr_data[14:0];
            CSR_HUE_RADIUS: cfg_in.hue_radius = csr_data[13:0];
            CSR_HUE_SHIFT:  cfg_in.hue_shift  = $signed(csr_data);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: MODE_ROTATE, hue_center: '0, hue_radius: '0, hue_shift: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // unpack the input word
   assign in_pix = '{last: req_tlast, red: req_tdata[23:16], green: req_tdata[15:8],
                     blue: req_tdata[7:0]};

   phr_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_pix   (in_pix),
      .out      (front_out),
      .pop      (pop),
      .fill     (fill)
   );

   phr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in          (front_out),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pix     (out_pix),
      .out_changed (rsp_tuser)
   );

   assign rsp_tdata = {out_pix.red, out_pix.green, out_pix.blue};
   assign rsp_tlast = out_pix.last;

   // nothing comes out right after reset: the pipeline valids are cleared
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word right after reset");

   // an accepted pixel always finds room in the queue
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (fill < CW'(QUEUE_DEPTH)))
      else $error("pixel accepted into a full queue");

   // a pixel pulled by the back end must be present in the queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (fill != '0))
      else $error("back end pulled from an empty queue");

   // a saturated pixel has one channel at full scale and one at zero
   a_saturate_span: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && cfg_ff.mode == MODE_SATURATE)
      |-> ((out_pix.red == 8'd255 || out_pix.green == 8'd255 || out_pix.blue == 8'd255)
        && (out_pix.red == 8'd0 || out_pix.green == 8'd0 || out_pix.blue == 8'd0)))
      else $error("saturated pixel lacks full and zero channels");

endmodule

/* tb/tb_pixel_hue_rotate_unit.sv */
// testbench for pixel_hue_rotate_unit: drives bgr pixel words, predicts each result
// with an independent hsv model and compares field by field; depends on phr_pkg
`timescale 1ns / 1ps

module tb_pixel_hue_rotate_unit;
   import phr_pkg::*;

   localparam int LATENCY = 60;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       changed;
      logic       last;
   } hue_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // blue[7:0], green[15:8], red[23:16]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // blue[7:0], green[15:8], red[23:16]
   logic        rsp_tuser;   // changed
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   // predictor copy of the registers
   mode_type    cur_mode;
   longint      cur_center;
   longint      cur_radius;
   longint      cur_shift;

   hue_result_type pending_pixels[$];
   int error_count;
   int result_count;
   int changed_count;
   int stall_pct;
   int burst_left;

   pixel_hue_rotate_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint wrap_degrees(longint h);
      longint m;
      m = h % 23040;
      if (m < 0) m += 23040;
      return m;
   endfunction

   function automatic logic [7:0] chan_byte(longint x);
      longint c;
      c = (x * 255) >>> 16;
      return (c > 255) ? 8'd255 : c[7:0];
   endfunction

   function automatic bit window_hit(longint h);
      longint lo, hi;
      lo = cur_center - cur_radius;
      hi = cur_center + cur_radius;
      if (h >= lo && h <= hi) return 1;
      if (lo < 0 && h - 23040 >= lo && h - 23040 <= hi) return 1;
      if (hi > 23040 && h + 23040 >= lo && h + 23040 <= hi) return 1;
      return 0;
   endfunction

   function automatic hue_result_type predict_pixel(logic [7:0] b, logic [7:0] g,
                                                    logic [7:0] r, logic last);
      hue_result_type res;
      longint mx, mn, d, h, s, v, diff, base, sector, f, fs, gs, p, q, t;
      longint cr, cg, cb;
      bit hit;
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      d = mx - mn;
      h = 0;
      if (d != 0) begin
         if (mx == r) begin
            diff = longint'(g) - longint'(b); base = 0;
         end else if (mx == g) begin
            diff = longint'(b) - longint'(r); base = 7680;
         end else begin
            diff = longint'(r) - longint'(g); base = 15360;
         end
         h = wrap_degrees((diff * 3840) / d + base);
      end
      s = (mx != 0) ? (d << 16) / mx : 0;
      v = ((mx << 16) + 254) / 255;
      if (cur_mode == MODE_ROTATE) begin
         hit = window_hit(h);
         if (hit) h = wrap_degrees(h + cur_shift);
      end else begin
         hit = (mx != 0 && d != 0);
         if (hit) begin
            s = 65536; v = 65536;
         end
      end
      res.blue = b; res.green = g; res.red = r;
      if (hit) begin
         sector = h / 3840;
         if (sector > 5) sector = 5;
         f = ((h % 3840) << 16) / 3840;
         fs = (f * s) >> 16;
         gs = ((65536 - f) * s) >> 16;
         p = (v * (65536 - s)) >> 16;
         q = (v * (65536 - fs)) >> 16;
         t = (v * (65536 - gs)) >> 16;
         case (sector)
            0: begin cr = v; cg = t; cb = p; end
            1: begin cr = q; cg = v; cb = p; end
            2: begin cr = p; cg = v; cb = t; end
            3: begin cr = p; cg = q; cb = v; end
            4: begin cr = t; cg = p; cb = v; end
            default: begin cr = v; cg = p; cb = q; end
         endcase
         res.red = chan_byte(cr);
         res.green = chan_byte(cg);
         res.blue = chan_byte(cb);
      end
      res.changed = hit;
      res.last = last;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("mismatch on result %0d: %s got %0d expected %0d",
               result_count, what, got, want);
   endtask

   // result checker with its own stall pattern
   always @(posedge clock) begin
      hue_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.blue) report_mismatch("blue", rsp_tdata[7:0], want.blue);
            if (rsp_tdata[15:8] !== want.green)
               report_mismatch("green", rsp_tdata[15:8], want.green);
            if (rsp_tdata[23:16] !== want.red)
               report_mismatch("red", rsp_tdata[23:16], want.red);
            if (rsp_tuser !== want.changed) report_mismatch("changed", rsp_tuser, want.changed);
            if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
            if (want.changed) changed_count++;
         end
         result_count++;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:       cur_mode = mode_type'(value[0]);
         CSR_HUE_CENTER: cur_center = value[14:0];
         CSR_HUE_RADIUS: cur_radius = value[13:0];
         CSR_HUE_SHIFT:  cur_shift = longint'($signed(value));
         default:        ;
      endcase
   endtask

   // stops the sender and waits until every expected result is back
   task automatic drain_pipeline();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic configure(bit m, int center, int radius, int shift);
      drain_pipeline();
      write_csr(CSR_MODE, 16'(m));
      write_csr(CSR_HUE_CENTER, 16'(center));
      write_csr(CSR_HUE_RADIUS, 16'(radius));
      write_csr(CSR_HUE_SHIFT, 16'(shift));
   endtask

   // one pixel word, called at a falling edge, returns at a falling edge with
   // valid still high so the next word can follow without a gap
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r, g, b};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_pixels.push_back(predict_pixel(b, g, r, last));
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_random_pixels(int count);
      for (int i = 0; i < count; i++)
         send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    ($urandom_range(15) == 0));
   endtask

   task automatic test_directed_rotate();
      configure(0, 0, 1920, 7680);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);        // black, hue 0 inside window
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);  // white
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);  // grey
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);      // pure red
      send_pixel(8'd255, 8'd0, 8'd254, 1'b0);    // hue just below 300, outside
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);      // pure green, outside
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);      // pure blue
      // window edges exactly: center 120 deg, radius 60 deg
      configure(0, 7680, 3840, -23040);
      send_pixel(8'd0, 8'd255, 8'd255, 1'b0);    // 60 deg, lower edge
      send_pixel(8'd255, 8'd255, 8'd0, 1'b0);    // 180 deg, upper edge
      send_pixel(8'd255, 8'd254, 8'd0, 1'b0);    // just past upper edge
      // extremes of the registers, window above full turn
      configure(0, 23039, 11520, 23040);
      send_pixel(8'd10, 8'd200, 8'd30, 1'b0);
      send_pixel(8'd200, 8'd10, 8'd30, 1'b1);
      // values beyond range: max center/radius fields and most negative shift
      configure(0, 16'h7fff, 16'h3fff, 16'h8000);
      send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
      send_pixel(8'd250, 8'd100, 8'd7, 1'b1);
   endtask

   task automatic test_directed_saturate();
      configure(1, 0, 0, 0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);        // black passes
      send_pixel(8'd77, 8'd77, 8'd77, 1'b0);     // grey passes
      send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
      send_pixel(8'd0, 8'd1, 8'd0, 1'b1);        // darkest colour
   endtask

   task automatic test_random_rotate(int phases, int per_phase);
      for (int k = 0; k < phases; k++) begin
         stall_pct = $urandom_range(3) * 20;
         configure(0, $urandom_range(23039), $urandom_range(11520),
                   int'($urandom_range(46080)) - 23040);
         send_random_pixels(per_phase);
      end
   endtask

   task automatic test_random_saturate(int count);
      stall_pct = 30;
      configure(1, $urandom_range(23039), $urandom_range(11520), 0);
      send_random_pixels(count);
   endtask

   // sender holds off until every result is back, then resumes at full rate
   task automatic test_full_drain();
      stall_pct = 0;
      configure(0, 11520, 11520, 100);
      send_random_pixels(20);
      drain_pipeline();
      burst_left = 1000;
      send_random_pixels(30);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      cur_mode = MODE_ROTATE; cur_center = 0; cur_radius = 0; cur_shift = 0;
      error_count = 0; result_count = 0; changed_count = 0;
      stall_pct = 0; burst_left = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_rotate();
      test_directed_saturate();
      test_random_rotate(6, 50);
      test_random_saturate(80);
      test_full_drain();
      drain_pipeline();
      if (pending_pixels.size() != 0) begin
         error_count++;
         $display("%0d expected results never arrived", pending_pixels.size());
      end
      $display("covered rotate and saturate modes, window edges and wrap");
      $display("%0d results checked, %0d of them changed", result_count, changed_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
